FILE: rtl/core/tplq_pkg.sv
// ----------------------------------------------------------------------------
// tplq_pkg
// Shared constants, types and helpers of the tree path max / LCA engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tplq_pkg;

  // table sizes
  localparam int MAX_NODES  = 1024;
  localparam int LOG_LEVELS = 10;
  localparam int COST_WIDTH = 16;

  // field and index widths
  localparam int NODE_W = 10;
  localparam int LV_W   = (LOG_LEVELS > 2) ? $clog2(LOG_LEVELS) : 1;
  localparam int ROWS   = MAX_NODES * LOG_LEVELS;
  localparam int ROW_W  = $clog2(ROWS);

  // controller states
  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_A_DEP, S_A_BASE, S_A_RD, S_A_WR,
    S_Q_DU, S_Q_DV, S_Q_SW,
    S_L_ANC, S_L_DEP, S_L_STEP, S_Q_EQ,
    S_B_U, S_B_V, S_B_STEP,
    S_F_U, S_F_V, S_F_FIN,
    S_PUT
  } state_e;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD,
    OP_A_DEP, OP_A_BASE, OP_A_RD, OP_A_WR,
    OP_Q_DU, OP_Q_DV, OP_Q_SW,
    OP_L_ANC, OP_L_DEP, OP_L_STEP, OP_Q_EQ,
    OP_B_U, OP_B_V, OP_B_STEP, OP_F_FIN,
    OP_PUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic bad_add;
    logic bad_query;
    logic lv_last_add;
    logic lv_zero;
    logic same_node;
    logic out_free;
  } dp_status_t;

  // flat row address of node n at level l
  function automatic logic [ROW_W-1:0] row_addr(input logic [NODE_W-1:0] n,
                                                input logic [LV_W-1:0] l);
    return ROW_W'(n) * ROW_W'(LOG_LEVELS) + ROW_W'(l);
  endfunction

  function automatic logic [COST_WIDTH-1:0] larger(input logic [COST_WIDTH-1:0] x,
                                                   input logic [COST_WIDTH-1:0] y);
    return (x > y) ? x : y;
  endfunction

endpackage

FILE: rtl/core/tree_path_max_lca_query.sv
// ----------------------------------------------------------------------------
// tree_path_max_lca_query
// Binary-lifting tables of a rooted weighted tree; answers LCA and path max.
// ----------------------------------------------------------------------------
// channel | direction | handshake               | words
// in      | to block  | in_valid_i / in_stall_o | action, node_a, node_b, edge_cost
// out     | from block| out_valid_o / out_stall_i | lca_node, path_max
//
// an add or query word holds the input stalled until its walk returns to idle;
// a query walk reads ancestor then depth on every lifting level, one after the
// other, as each table memory has a single read port.
// reset clears the sequencer and the result valid; tables need no clearing,
// node 0 reads as zero by address decode. a stalled result word does not
// block the next input word, but holds the next query in its last state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tree_path_max_lca_query (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [9:0]  node_a_i,
  input  logic [9:0]  node_b_i,
  input  logic [15:0] edge_cost_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  lca_node_o,
  output logic [15:0] path_max_o
);
  import tplq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  // sequencer
  tplq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tables and walk registers
  tplq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (action_i),
    .node_a_i    (node_a_i),
    .node_b_i    (node_b_i),
    .edge_cost_i (edge_cost_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .lca_node_o  (lca_node_o),
    .path_max_o  (path_max_o)
  );

endmodule

FILE: rtl/core/tplq_ctrl.sv
// ----------------------------------------------------------------------------
// tplq_ctrl
// Sequencer: steps the add and query walks, one table access per state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tplq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tplq_pkg::dp_status_t sts_i,
  output tplq_pkg::dp_cmd_t   cmd_o
);
  import tplq_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DISP;
      S_DISP: begin
        if (!sts_i.is_query) state_d = sts_i.bad_add ? S_IDLE : S_A_DEP;
        else                 state_d = sts_i.bad_query ? S_PUT : S_Q_DU;
      end
      S_A_DEP:  state_d = S_A_BASE;
      S_A_BASE: state_d = S_A_RD;
      S_A_RD:   state_d = S_A_WR;
      S_A_WR:   state_d = sts_i.lv_last_add ? S_IDLE : S_A_RD;
      S_Q_DU:   state_d = S_Q_DV;
      S_Q_DV:   state_d = S_Q_SW;
      S_Q_SW:   state_d = S_L_ANC;
      S_L_ANC:  state_d = S_L_DEP;
      S_L_DEP:  state_d = S_L_STEP;
      S_L_STEP: state_d = sts_i.lv_zero ? S_Q_EQ : S_L_ANC;
      S_Q_EQ:   state_d = sts_i.same_node ? S_PUT : S_B_U;
      S_B_U:    state_d = S_B_V;
      S_B_V:    state_d = S_B_STEP;
      S_B_STEP: state_d = sts_i.lv_zero ? S_F_U : S_B_U;
      S_F_U:    state_d = S_F_V;
      S_F_V:    state_d = S_F_FIN;
      S_F_FIN:  state_d = S_PUT;
      S_PUT:    if (sts_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.op   = OP_NONE;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE:   if (in_valid_i) cmd_o.op = OP_LOAD;
      S_A_DEP:  cmd_o.op = OP_A_DEP;
      S_A_BASE: cmd_o.op = OP_A_BASE;
      S_A_RD:   cmd_o.op = OP_A_RD;
      S_A_WR:   cmd_o.op = OP_A_WR;
      S_Q_DU:   cmd_o.op = OP_Q_DU;
      S_Q_DV:   cmd_o.op = OP_Q_DV;
      S_Q_SW:   cmd_o.op = OP_Q_SW;
      S_L_ANC:  cmd_o.op = OP_L_ANC;
      S_L_DEP:  cmd_o.op = OP_L_DEP;
      S_L_STEP: cmd_o.op = OP_L_STEP;
      S_Q_EQ:   cmd_o.op = OP_Q_EQ;
      S_B_U:    cmd_o.op = OP_B_U;
      S_B_V:    cmd_o.op = OP_B_V;
      S_B_STEP: cmd_o.op = OP_B_STEP;
      S_F_U:    cmd_o.op = OP_B_U;
      S_F_V:    cmd_o.op = OP_B_V;
      S_F_FIN:  cmd_o.op = OP_F_FIN;
      S_PUT:    if (sts_i.out_free) cmd_o.op = OP_PUT;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

endmodule

FILE: rtl/core/tplq_dp.sv
// ----------------------------------------------------------------------------
// tplq_dp
// Datapath: depth, ancestor and jump-max memories, walk registers, result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tplq_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tplq_pkg::dp_cmd_t                   cmd_i,
  output tplq_pkg::dp_status_t                sts_o,
  input  logic                                action_i,
  input  logic [tplq_pkg::NODE_W-1:0]         node_a_i,
  input  logic [tplq_pkg::NODE_W-1:0]         node_b_i,
  input  logic [15:0]                         edge_cost_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tplq_pkg::NODE_W-1:0]         lca_node_o,
  output logic [15:0]                         path_max_o
);
  import tplq_pkg::*;

  localparam logic [NODE_W-1:0] DEPTH_TOP = NODE_W'(MAX_NODES - 1);
  localparam logic [LV_W-1:0]   LV_TOP    = LV_W'(LOG_LEVELS - 1);
  localparam logic [LV_W-1:0]   LV_LAST   = LV_W'(LOG_LEVELS - 2);

  // memories; node 0 rows are never written and read as zero
  logic [NODE_W-1:0]     dep_mem [MAX_NODES];
  logic [NODE_W-1:0]     anc_mem [ROWS];
  logic [COST_WIDTH-1:0] jmp_mem [ROWS];

  // walk registers
  logic                  act_q;
  logic [NODE_W-1:0]     u_q, v_q, du_q, dv_q, lca_q, cur_anc_q, up_q;
  logic [COST_WIDTH-1:0] cost_q, res_q, cur_jmp_q, jw_q;
  logic [LV_W-1:0]       lv_q;

  // read data
  logic [NODE_W-1:0]     dep_raw_q, anc_raw_q;
  logic [COST_WIDTH-1:0] jmp_raw_q;
  logic                  dep_zero_q, row_zero_q;
  logic [NODE_W-1:0]     dep_rd, anc_rd;
  logic [COST_WIDTH-1:0] jmp_rd;

  // result word
  logic                  out_valid_q;
  logic [NODE_W-1:0]     out_lca_q;
  logic [15:0]           out_max_q;

  // memory ports
  logic [NODE_W-1:0]     dep_raddr, dep_waddr, dep_wdata, row_node;
  logic [ROW_W-1:0]      row_waddr;
  logic [NODE_W-1:0]     anc_wdata;
  logic [COST_WIDTH-1:0] jmp_wdata, new_jmp;
  logic                  dep_we, row_we;
  logic [LV_W-1:0]       row_lv;

  assign dep_rd = dep_zero_q ? '0 : dep_raw_q;
  assign anc_rd = row_zero_q ? '0 : anc_raw_q;
  assign jmp_rd = row_zero_q ? '0 : jmp_raw_q;
  assign new_jmp = larger(cur_jmp_q, jmp_rd);

  // read address selection
  always_comb begin
    dep_raddr = u_q;
    row_node  = u_q;
    row_lv    = lv_q;
    case (cmd_i.op)
      OP_A_DEP: dep_raddr = u_q;
      OP_Q_DV:  dep_raddr = v_q;
      OP_L_DEP: dep_raddr = anc_rd;
      OP_A_RD:  row_node  = cur_anc_q;
      OP_B_V:   row_node  = v_q;
      default:  dep_raddr = u_q;
    endcase
  end

  // write port selection
  always_comb begin
    dep_we    = (cmd_i.op == OP_A_BASE);
    dep_waddr = v_q;
    dep_wdata = (dep_rd >= DEPTH_TOP) ? DEPTH_TOP : dep_rd + NODE_W'(1);
    row_we    = (cmd_i.op == OP_A_BASE) || (cmd_i.op == OP_A_WR);
    row_waddr = row_addr(v_q, '0);
    anc_wdata = cur_anc_q;
    jmp_wdata = cur_jmp_q;
    if (cmd_i.op == OP_A_WR) begin
      row_waddr = row_addr(v_q, lv_q + LV_W'(1));
      anc_wdata = anc_rd;
      jmp_wdata = new_jmp;
    end
  end

  // memory access
  always_ff @(posedge clk_i) begin
    if (dep_we) dep_mem[dep_waddr] <= dep_wdata;
    if (row_we) begin
      anc_mem[row_waddr] <= anc_wdata;
      jmp_mem[row_waddr] <= jmp_wdata;
    end
    dep_raw_q  <= dep_mem[dep_raddr];
    dep_zero_q <= (dep_raddr == '0);
    anc_raw_q  <= anc_mem[row_addr(row_node, row_lv)];
    jmp_raw_q  <= jmp_mem[row_addr(row_node, row_lv)];
    row_zero_q <= (row_node == '0);
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        act_q  <= action_i;
        u_q    <= node_a_i;
        v_q    <= node_b_i;
        cost_q <= COST_WIDTH'(edge_cost_i);
        res_q  <= '0;
        lca_q  <= '0;
      end
      OP_A_DEP: begin
        cur_anc_q <= u_q;
        cur_jmp_q <= (u_q == '0) ? '0 : cost_q;
        lv_q      <= '0;
      end
      OP_A_WR: begin
        cur_anc_q <= anc_rd;
        cur_jmp_q <= new_jmp;
        lv_q      <= lv_q + LV_W'(1);
      end
      OP_Q_DV: du_q <= dep_rd;
      OP_Q_SW: begin
        lv_q <= LV_TOP;
        if (du_q < dep_rd) begin
          u_q  <= v_q;
          v_q  <= u_q;
          dv_q <= du_q;
        end else begin
          dv_q <= dep_rd;
        end
      end
      OP_L_DEP: begin
        up_q <= anc_rd;
        jw_q <= jmp_rd;
      end
      OP_L_STEP: begin
        if (dep_rd >= dv_q) begin
          res_q <= larger(res_q, jw_q);
          u_q   <= up_q;
        end
        if (lv_q != '0) lv_q <= lv_q - LV_W'(1);
      end
      OP_Q_EQ: begin
        lv_q <= LV_TOP;
        if (u_q == v_q) lca_q <= u_q;
      end
      OP_B_V: begin
        up_q <= anc_rd;
        jw_q <= jmp_rd;
      end
      OP_B_STEP: begin
        if (up_q != anc_rd) begin
          res_q <= larger(res_q, larger(jw_q, jmp_rd));
          u_q   <= up_q;
          v_q   <= anc_rd;
        end
        if (lv_q != '0) lv_q <= lv_q - LV_W'(1);
      end
      OP_F_FIN: begin
        res_q <= larger(res_q, larger(jw_q, jmp_rd));
        lca_q <= up_q;
      end
      default: lv_q <= lv_q;
    endcase
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_PUT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_PUT) begin
      out_lca_q <= lca_q;
      out_max_q <= 16'(res_q);
    end
  end

  // status to the sequencer
  always_comb begin
    sts_o.is_query    = act_q;
    sts_o.bad_query   = (32'(u_q) >= 32'(MAX_NODES)) || (32'(v_q) >= 32'(MAX_NODES));
    sts_o.bad_add     = (v_q == '0) || sts_o.bad_query;
    sts_o.lv_last_add = (lv_q == LV_LAST);
    sts_o.lv_zero     = (lv_q == '0);
    sts_o.same_node   = (u_q == v_q);
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign lca_node_o  = out_lca_q;
  assign path_max_o  = out_max_q;

endmodule

FILE: rtl/core/tplq_chk.sv
// ----------------------------------------------------------------------------
// tplq_chk
// Port-level checks of the tree path max / LCA engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tplq_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        action_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [9:0]  lca_node_o,
  input logic [15:0] path_max_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(lca_node_o) && $stable(path_max_o))
    else $error("result word changed while stalled");

  // an accepted word keeps the block busy next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new result only appears at the end of a walk
  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word without work in progress");

  // an add never produces a result: accepted add keeps valid from rising next cycle
  a_add_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !action_i |=> !$rose(out_valid_o))
    else $error("result word right after add");

endmodule

bind tree_path_max_lca_query tplq_chk u_tplq_chk (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the tree path max / LCA engine: builds random trees
// parent first, queries node pairs and compares every result word with a
// binary-lifting predictor kept in the bench, under varied handshake idling.
// ----------------------------------------------------------------------------

module tb;
  import tplq_pkg::*;

  localparam int LEVELS   = LOG_LEVELS;
  localparam int NODES    = MAX_NODES;
  localparam int DOG_MAX  = 20000;
  localparam int DRAIN    = 150;
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct {
    logic        act;
    logic [9:0]  a;
    logic [9:0]  b;
    logic [15:0] cost;
  } word_t;

  typedef struct {
    logic [9:0]  lca;
    logic [15:0] pmax;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        action_i = 1'b0;
  logic [9:0]  node_a_i = '0;
  logic [9:0]  node_b_i = '0;
  logic [15:0] edge_cost_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [9:0]  lca_node_o;
  logic [15:0] path_max_o;

  tree_path_max_lca_query dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .node_a_i,
    .node_b_i, .edge_cost_i, .out_valid_o, .out_stall_i, .lca_node_o,
    .path_max_o
  );

  always #1 clk_i = ~clk_i;

  // predictor state: lifting tables of the tree as the bench sees it
  int unsigned depth_m [NODES];
  int unsigned anc_m   [NODES][LEVELS];
  int unsigned jmax_m  [NODES][LEVELS];

  word_t   pending_q[$];
  answer_t answer_q[$];
  int      sender_idle = 0;
  int      receiver_idle = 0;
  int      errors = 0;
  int      n_adds = 0;
  int      n_queries = 0;
  int      dog = 0;

  // generator bookkeeping
  int unsigned free_q[$];
  int unsigned added_q[$];
  int unsigned last_node = 0;

  function automatic int unsigned bigger(int unsigned x, int unsigned y);
    return (x > y) ? x : y;
  endfunction

  // binary-lifting row build for one add word
  function automatic void tree_add(int unsigned child, int unsigned parent,
                                   int unsigned cost);
    int unsigned mid;
    if (child == 0 || child >= NODES || parent >= NODES) return;
    depth_m[child] = (depth_m[parent] >= NODES - 1) ? NODES - 1
                                                     : depth_m[parent] + 1;
    anc_m[child][0]  = parent;
    jmax_m[child][0] = (parent == 0) ? 0 : (cost & 16'hFFFF);
    for (int lv = 0; lv < LEVELS - 1; lv++) begin
      mid = anc_m[child][lv];
      anc_m[child][lv+1]  = anc_m[mid][lv];
      jmax_m[child][lv+1] = bigger(jmax_m[child][lv], jmax_m[mid][lv]);
    end
  endfunction

  // lowest common ancestor and path maximum of a node pair
  function automatic answer_t tree_query(int unsigned u, int unsigned v);
    answer_t     r;
    int unsigned best;
    int unsigned t;
    int unsigned up;
    best = 0;
    r.lca = '0;
    r.pmax = '0;
    if (u >= NODES || v >= NODES) return r;
    if (depth_m[u] < depth_m[v]) begin
      t = u; u = v; v = t;
    end
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      up = anc_m[u][lv];
      if (depth_m[up] >= depth_m[v]) begin
        best = bigger(best, jmax_m[u][lv]);
        u = up;
      end
    end
    if (u == v) begin
      r.lca = u[9:0];
      r.pmax = best[15:0];
      return r;
    end
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      if (anc_m[u][lv] != anc_m[v][lv]) begin
        best = bigger(best, jmax_m[u][lv]);
        best = bigger(best, jmax_m[v][lv]);
        u = anc_m[u][lv];
        v = anc_m[v][lv];
      end
    end
    best = bigger(best, jmax_m[u][0]);
    best = bigger(best, jmax_m[v][0]);
    r.lca = anc_m[u][0][9:0];
    r.pmax = best[15:0];
    return r;
  endfunction

  // queue helpers for the generator
  task automatic push_word(logic act, int unsigned a, int unsigned b, int unsigned c);
    word_t w;
    w.act = act;
    w.a = a[9:0];
    w.b = b[9:0];
    w.cost = c[15:0];
    pending_q.push_back(w);
  endtask

  task automatic push_add(int unsigned parent, int unsigned child, int unsigned c);
    push_word(ACT_ADD, parent, child, c);
    added_q.push_back(child);
    last_node = child;
  endtask

  function automatic int unsigned take_fresh();
    int idx;
    int unsigned n;
    idx = $urandom_range(0, free_q.size() - 1);
    n = free_q[idx];
    free_q.delete(idx);
    return n;
  endfunction

  function automatic int unsigned any_added();
    return added_q[$urandom_range(0, added_q.size() - 1)];
  endfunction

  // random words: mostly tree growth and queries, some odd adds
  task automatic gen_random(int count);
    int r;
    int unsigned parent;
    int unsigned child;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (added_q.size() == 0 || (r < 45 && free_q.size() > 0)) begin
        if (added_q.size() == 0 || $urandom_range(0, 9) == 0) parent = 0;
        else if ($urandom_range(0, 1) == 1) parent = last_node;
        else parent = any_added();
        child = take_fresh();
        push_add(parent, child, $urandom);
      end else if (r < 49) begin
        // child index zero: ignored
        push_word(ACT_ADD, any_added(), 0, $urandom);
      end else if (r < 52) begin
        // re-add an existing node under another present node or itself
        child = any_added();
        parent = ($urandom_range(0, 3) == 0) ? child : any_added();
        push_word(ACT_ADD, parent, child, $urandom);
        last_node = child;
      end else begin
        push_word(ACT_QUERY, ($urandom_range(0, 19) == 0) ? 0 : any_added(),
                  any_added(), $urandom);
      end
    end
  endtask

  // wait until the sender has run dry and every result word is back
  task automatic drain_all();
    while (pending_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // driver: presents words from the pending queue, predicts on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (action_i == ACT_ADD) begin
          tree_add(node_b_i, node_a_i, edge_cost_i);
          n_adds++;
        end else begin
          answer_q.push_back(tree_query(node_a_i, node_b_i));
          n_queries++;
        end
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= sender_idle) begin
          word_t w;
          w = pending_q.pop_front();
          in_valid_i  <= 1'b1;
          action_i    <= w.act;
          node_a_i    <= w.a;
          node_b_i    <= w.b;
          edge_cost_i <= w.cost;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks result words against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result word lca %0d max %0d", $time,
                   lca_node_o, path_max_o);
          errors++;
        end else begin
          answer_t e;
          e = answer_q.pop_front();
          if (lca_node_o !== e.lca) begin
            $display("%0t: lca_node expected %0d actual %0d", $time, e.lca, lca_node_o);
            errors++;
          end
          if (path_max_o !== e.pmax) begin
            $display("%0t: path_max expected %0d actual %0d", $time, e.pmax, path_max_o);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < receiver_idle);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) dog <= 0;
      else dog <= dog + 1;
      if (dog >= DOG_MAX) begin
        $display("timeout after %0d idle cycles", dog);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    for (int n = 0; n < NODES; n++) begin
      depth_m[n] = 0;
      for (int lv = 0; lv < LEVELS; lv++) begin
        anc_m[n][lv] = 0;
        jmax_m[n][lv] = 0;
      end
    end
    for (int n = 1; n < NODES; n++) free_q.push_back(n);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: root edge, extremes, ignored child, ancestor and disjoint pairs
    free_q.delete(free_q.size() - 1);
    free_q.delete(0);
    free_q.delete(0);
    free_q.delete(0);
    push_add(0, 1, 16'hFFFF);
    push_add(1, 2, 16'hFFFF);
    push_add(2, 3, 16'h0000);
    push_add(0, 1023, 16'h1234);
    push_word(ACT_ADD, 1, 0, 16'hAAAA);
    push_word(ACT_QUERY, 1, 1, 0);
    push_word(ACT_QUERY, 3, 1, 16'hFFFF);
    push_word(ACT_QUERY, 1, 3, 0);
    push_word(ACT_QUERY, 3, 1023, 0);
    push_word(ACT_QUERY, 0, 3, 0);
    push_word(ACT_QUERY, 0, 1023, 0);
    push_word(ACT_QUERY, 1023, 1023, 0);
    push_word(ACT_ADD, 1023, 2, 16'h0001);
    push_word(ACT_QUERY, 2, 3, 0);
    push_word(ACT_ADD, 3, 3, 16'h00FF);
    push_word(ACT_QUERY, 3, 1023, 0);
    drain_all();

    // phase one: slow sender, heavily stalling receiver
    sender_idle = 32;
    receiver_idle = 81;
    gen_random(320);
    drain_all();

    // phase two: roles swapped
    sender_idle = 81;
    receiver_idle = 32;
    gen_random(320);
    drain_all();

    // phase three: full rate
    sender_idle = 0;
    receiver_idle = 0;
    gen_random(310);
    drain_all();

    $display("covered %0d add words and %0d queries over three idling phases",
             n_adds, n_queries);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/tplq_pkg.sv
rtl/core/tplq_ctrl.sv
rtl/core/tplq_dp.sv
rtl/core/tree_path_max_lca_query.sv
rtl/core/tplq_chk.sv
tb/tb.sv
